>>> hdl/ahvg_pkg.sv
// Shared constants and types for the arrowhead vertex generator.
// Used by the divider cell and the top level; depends on nothing else.
`default_nettype none

package ahvg_pkg;

  // Default geometry widths for the top level.
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int FRAC_BITS_DEFAULT  = 8;

  // Head size registers.
  localparam int REG_BITS = 8;
  localparam logic [REG_BITS-1:0] BARB_BACK_RESET = 8'd5;
  localparam logic [REG_BITS-1:0] BARB_SIDE_RESET = 8'd3;

  // Number of barb coordinates that are divided in parallel.
  localparam int LANES = 4;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BARB_BACK = 1'b0,
    CFG_BARB_SIDE = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

>>> hdl/ahvg_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cell.
// Depends on nothing but its parameters.
`default_nettype none

module ahvg_sqrt_cell #(
  parameter int RB   = 25,
  parameter int STEP = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*RB-1:0]   rad_in,
  input  wire logic [RB+1:0]     rem_in,
  input  wire logic [RB-1:0]     root_in,
  output logic      [2*RB-1:0]   rad_out,
  output logic      [RB+1:0]     rem_out,
  output logic      [RB-1:0]     root_out
);

  logic [RB+1:0] rem_shift;
  logic [RB+1:0] trial;
  logic          take;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_shift = {rem_in[RB-1:0], rad_in[2*STEP +: 2]};
    trial     = {root_in, 2'b01};
    take      = (rem_shift >= trial);
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in;
      rem_out  <= take ? (rem_shift - trial) : rem_shift;
      root_out <= {root_in[RB-2:0], take};
    end
  end

endmodule

`default_nettype wire

>>> hdl/ahvg_div_cell.sv
// One cell of the divider chain: resolves one quotient bit for all lanes.
// Depends on ahvg_pkg for the lane count.
`default_nettype none

module ahvg_div_cell #(
  parameter int RB   = 25,
  parameter int DW   = 42,
  parameter int QB   = 18,
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RB-1:0] divisor_in,
  input  wire logic [DW-1:0] rem_in  [ahvg_pkg::LANES],
  input  wire logic [QB-1:0] quo_in  [ahvg_pkg::LANES],
  output logic      [RB-1:0] divisor_out,
  output logic      [DW-1:0] rem_out [ahvg_pkg::LANES],
  output logic      [QB-1:0] quo_out [ahvg_pkg::LANES]
);

  logic [DW-1:0] trial;
  logic          take [ahvg_pkg::LANES];

  // The divisor shifted to this cell's quotient bit.
  always_comb begin
    trial = DW'(divisor_in) << STEP;
    for (int i = 0; i < ahvg_pkg::LANES; i++) begin
      take[i] = (rem_in[i] >= trial);
    end
  end

  // Subtract where it fits and hand the lanes on.
  always_ff @(posedge clk) begin
    if (en) begin
      divisor_out <= divisor_in;
      for (int i = 0; i < ahvg_pkg::LANES; i++) begin
        rem_out[i] <= take[i] ? (rem_in[i] - trial) : rem_in[i];
        quo_out[i] <= {quo_in[i][QB-2:0], take[i]};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/arrow_head_vertex_generator.sv
// Top level of the arrowhead vertex generator: input stages, square root and
// divider cell chains, rounding stage. Depends on ahvg_pkg and both cells.
//
// Usage:
//   Input channel: in_valid / in_stall with tail, tip and offset coordinates.
//   Output channel: out_valid / out_stall with shifted tail and tip and the
//   two barb points. A transfer happens when valid is high and stall is low.
//   Configuration: cfg_write with cfg_index and cfg_data sets the head length
//   (index 0) or the head width (index 1); write only while the block is idle.
//   Throughput: one item per cycle when the output is not stalled.
//   Pipeline: input stages, then one square root cell per root bit and one
//   divider cell per quotient bit, then the rounding stage.
//   Stall: the whole pipeline holds while a result waits at the output and
//   out_stall is high; in_stall is raised in the same cycle.
//   Reset: all stages empty, head length 5 and head width 3.
`default_nettype none

module arrow_head_vertex_generator #(
  parameter int COORD_BITS = ahvg_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = ahvg_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [ahvg_pkg::REG_BITS-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] tail_x,
  input  wire logic signed [COORD_BITS-1:0] tail_y,
  input  wire logic signed [COORD_BITS-1:0] tip_x,
  input  wire logic signed [COORD_BITS-1:0] tip_y,
  input  wire logic signed [COORD_BITS-1:0] offset_x,
  input  wire logic signed [COORD_BITS-1:0] offset_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_tail_x,
  output logic signed [COORD_BITS-1:0]      out_tail_y,
  output logic signed [COORD_BITS-1:0]      out_tip_x,
  output logic signed [COORD_BITS-1:0]      out_tip_y,
  output logic signed [COORD_BITS-1:0]      barb_one_x,
  output logic signed [COORD_BITS-1:0]      barb_one_y,
  output logic signed [COORD_BITS-1:0]      barb_two_x,
  output logic signed [COORD_BITS-1:0]      barb_two_y
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int RBITS = ahvg_pkg::REG_BITS;
  localparam int LN    = ahvg_pkg::LANES;
  localparam int DXW   = C + 1;
  localparam int SQW   = 2 * DXW;
  localparam int PW    = DXW + RBITS + 1;
  localparam int NW    = PW + 1;
  localparam int MW    = NW - 1;
  localparam int RB    = C + 1 + F;
  localparam int DW    = MW + 2 * F;
  localparam int QB    = F + 10;
  localparam int TW    = ((C + F) > (QB + 1) ? (C + F) : (QB + 1)) + 2;
  localparam int NS    = 4 + RB + QB + 1;
  localparam int SIDEW = 4 * C + LN;

  localparam logic signed [TW-1:0] SAT_HI = {{(TW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [TW-1:0] HALF   = TW'(1) << (F - 1);
  localparam logic signed [TW-1:0] ROUND  = (TW'(1) << F) - TW'(1);

  // Saturating add of two coordinates.
  function automatic logic signed [C-1:0] sat_add(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
    logic signed [C:0] sum;
    sum = {a[C-1], a} + {b[C-1], b};
    if (sum[C] != sum[C-1]) begin
      sat_add = sum[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    end else begin
      sat_add = sum[C-1:0];
    end
  endfunction

  // Configuration registers.
  logic [RBITS-1:0] barb_back;
  logic [RBITS-1:0] barb_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      barb_back <= ahvg_pkg::BARB_BACK_RESET;
      barb_side <= ahvg_pkg::BARB_SIDE_RESET;
    end else if (cfg_write) begin
      case (ahvg_pkg::cfg_index_t'(cfg_index))
        ahvg_pkg::CFG_BARB_BACK: barb_back <= cfg_data;
        ahvg_pkg::CFG_BARB_SIDE: barb_side <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: move whenever the output slot is free or being taken.
  logic          adv;
  logic [NS-1:0] vld;

  assign adv      = !vld[NS-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Stage 0: offset both points with saturation.
  logic signed [C-1:0] s0_x1, s0_y1, s0_x2, s0_y2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x1 <= sat_add(tail_x, offset_x);
      s0_y1 <= sat_add(tail_y, offset_y);
      s0_x2 <= sat_add(tip_x, offset_x);
      s0_y2 <= sat_add(tip_y, offset_y);
    end
  end

  // Stage 1: direction vector; coincident points use the unit x direction.
  logic signed [C-1:0]   s1_x1, s1_y1, s1_x2, s1_y2;
  logic signed [DXW-1:0] s1_dx, s1_dy;
  logic signed [DXW-1:0] dx_raw, dy_raw;

  always_comb begin
    dx_raw = {s0_x2[C-1], s0_x2} - {s0_x1[C-1], s0_x1};
    dy_raw = {s0_y2[C-1], s0_y2} - {s0_y1[C-1], s0_y1};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x1 <= s0_x1;
      s1_y1 <= s0_y1;
      s1_x2 <= s0_x2;
      s1_y2 <= s0_y2;
      s1_dx <= (dx_raw == '0 && dy_raw == '0) ? DXW'(1) : dx_raw;
      s1_dy <= dy_raw;
    end
  end

  // Stage 2: squares and head size products.
  logic signed [C-1:0]   s2_x1, s2_y1, s2_x2, s2_y2;
  logic signed [SQW-1:0] s2_xx, s2_yy;
  logic signed [PW-1:0]  s2_lx, s2_ly, s2_wx, s2_wy;
  logic signed [RBITS:0] len_s, wid_s;

  assign len_s = $signed({1'b0, barb_back});
  assign wid_s = $signed({1'b0, barb_side});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x1 <= s1_x1;
      s2_y1 <= s1_y1;
      s2_x2 <= s1_x2;
      s2_y2 <= s1_y2;
      s2_xx <= s1_dx * s1_dx;
      s2_yy <= s1_dy * s1_dy;
      s2_lx <= len_s * s1_dx;
      s2_ly <= len_s * s1_dy;
      s2_wx <= wid_s * s1_dx;
      s2_wy <= wid_s * s1_dy;
    end
  end

  // Stage 3: radicand and the four barb numerators as sign and magnitude.
  logic signed [C-1:0]  s3_x1, s3_y1, s3_x2, s3_y2;
  logic [2*RB-1:0]      s3_rad;
  logic [LN-1:0]        s3_neg;
  logic [MW-1:0]        s3_mag [LN];
  logic [SQW-1:0]       sum_sq;
  logic signed [NW-1:0] num [LN];

  always_comb begin
    sum_sq = s2_xx + s2_yy;
    num[0] = NW'(s2_wy) - NW'(s2_lx);
    num[1] = -NW'(s2_ly) - NW'(s2_wx);
    num[2] = -NW'(s2_lx) - NW'(s2_wy);
    num[3] = NW'(s2_wx) - NW'(s2_ly);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x1  <= s2_x1;
      s3_y1  <= s2_y1;
      s3_x2  <= s2_x2;
      s3_y2  <= s2_y2;
      s3_rad <= {sum_sq, {(2*F){1'b0}}};
      for (int i = 0; i < LN; i++) begin
        s3_neg[i] <= num[i][NW-1];
        s3_mag[i] <= num[i][NW-1] ? MW'(-num[i]) : MW'(num[i]);
      end
    end
  end

  // Coordinates and signs travel beside the cell chains.
  logic [SIDEW-1:0] side_s3;
  logic [SIDEW-1:0] side_pipe [1:RB+QB];

  assign side_s3 = {s3_x1, s3_y1, s3_x2, s3_y2, s3_neg};

  always_ff @(posedge clk) begin
    if (adv) begin
      side_pipe[1] <= side_s3;
      for (int k = 2; k <= RB + QB; k++) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  // Numerator magnitudes wait while the root is formed.
  logic [MW-1:0] mag_pipe [1:RB][LN];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_pipe[1] <= s3_mag;
      for (int k = 2; k <= RB; k++) begin
        mag_pipe[k] <= mag_pipe[k-1];
      end
    end
  end

  // Square root chain, most significant root bit first.
  logic [2*RB-1:0] rad_c  [RB+1];
  logic [RB+1:0]   rem_c  [RB+1];
  logic [RB-1:0]   root_c [RB+1];

  assign rad_c[0]  = s3_rad;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    ahvg_sqrt_cell #(
      .RB  (RB),
      .STEP(RB - 1 - k)
    ) u_cell (
      .clk     (clk),
      .en      (adv),
      .rad_in  (rad_c[k]),
      .rem_in  (rem_c[k]),
      .root_in (root_c[k]),
      .rad_out (rad_c[k+1]),
      .rem_out (rem_c[k+1]),
      .root_out(root_c[k+1])
    );
  end

  // Divider chain over the four barb lanes, sharing the root as divisor.
  logic [RB-1:0] dvs_c [QB+1];
  logic [DW-1:0] drem_c [QB+1][LN];
  logic [QB-1:0] quo_c  [QB+1][LN];

  assign dvs_c[0] = root_c[RB];
  for (genvar i = 0; i < LN; i++) begin : g_div_init
    assign drem_c[0][i] = {mag_pipe[RB][i], {(2*F){1'b0}}};
    assign quo_c[0][i]  = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    ahvg_div_cell #(
      .RB  (RB),
      .DW  (DW),
      .QB  (QB),
      .STEP(QB - 1 - k)
    ) u_cell (
      .clk        (clk),
      .en         (adv),
      .divisor_in (dvs_c[k]),
      .rem_in     (drem_c[k]),
      .quo_in     (quo_c[k]),
      .divisor_out(dvs_c[k+1]),
      .rem_out    (drem_c[k+1]),
      .quo_out    (quo_c[k+1])
    );
  end

  // Final stage: add to the tip, add one half, truncate toward zero, saturate.
  logic signed [C-1:0]  fx1, fy1, fx2, fy2;
  logic [LN-1:0]        fneg;
  logic signed [C-1:0]  barb [LN];
  logic signed [QB:0]   qs;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] shifted;
  logic signed [C-1:0]  base;

  assign {fx1, fy1, fx2, fy2, fneg} = side_pipe[RB+QB];

  always_comb begin
    qs      = '0;
    total   = '0;
    shifted = '0;
    base    = '0;
    for (int i = 0; i < LN; i++) begin
      base    = (i % 2 == 0) ? fx2 : fy2;
      qs      = fneg[i] ? -$signed({1'b0, quo_c[QB][i]}) : $signed({1'b0, quo_c[QB][i]});
      total   = (TW'(base) <<< F) + TW'(qs) + HALF;
      shifted = $signed(total + (total[TW-1] ? ROUND : TW'(0))) >>> F;
      if (shifted > SAT_HI) begin
        barb[i] = SAT_HI[C-1:0];
      end else if (shifted < SAT_LO) begin
        barb[i] = SAT_LO[C-1:0];
      end else begin
        barb[i] = shifted[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tail_x <= fx1;
      out_tail_y <= fy1;
      out_tip_x  <= fx2;
      out_tip_y  <= fy2;
      barb_one_x <= barb[0];
      barb_one_y <= barb[1];
      barb_two_x <= barb[2];
      barb_two_y <= barb[3];
    end
  end

`ifndef SYNTHESIS
  // The length of a valid segment is never below one pixel.
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    vld[3+RB] |-> (root_c[RB] >= (RB'(1) << F)))
    else $error("root below one pixel");

  // The quotient fits its bits: the remainders of lanes 0 and 3 end below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[3+RB+QB] |-> (drem_c[QB][0] < DW'(dvs_c[QB])) && (drem_c[QB][3] < DW'(dvs_c[QB])))
    else $error("divider remainder not below divisor");

  // A result appears only when an item sat in the stage before the output.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[NS-2]))
    else $error("result without a source item");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the arrowhead vertex generator.
// Depends on ahvg_pkg and arrow_head_vertex_generator, and through it on both cells.
`timescale 1ns / 1ps

module tb;

  localparam int CW = 16;
  localparam int FB = 8;
  localparam int PIPE_DEPTH = 5 + (CW + 1 + FB) + (FB + 10);
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic signed [CW-1:0] tx, ty, px, py, ox, oy;
  } segment_t;
  typedef logic [7:0][CW-1:0] vertices_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = ahvg_pkg::CFG_BARB_BACK;
  logic [ahvg_pkg::REG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] tail_x = '0, tail_y = '0, tip_x = '0, tip_y = '0;
  logic signed [CW-1:0] offset_x = '0, offset_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_tail_x, out_tail_y, out_tip_x, out_tip_y;
  logic signed [CW-1:0] barb_one_x, barb_one_y, barb_two_x, barb_two_y;

  // Local copy of the head size registers.
  longint head_len = ahvg_pkg::BARB_BACK_RESET;
  longint head_wid = ahvg_pkg::BARB_SIDE_RESET;

  vertices_t pending_vertices[$];
  int mismatches = 0;
  int segments_sent = 0;
  int vertex_sets_checked = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  arrow_head_vertex_generator i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .tail_x(tail_x), .tail_y(tail_y), .tip_x(tip_x), .tip_y(tip_y),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tail_x(out_tail_x), .out_tail_y(out_tail_y),
    .out_tip_x(out_tip_x), .out_tip_y(out_tip_y),
    .barb_one_x(barb_one_x), .barb_one_y(barb_one_y),
    .barb_two_x(barb_two_x), .barb_two_y(barb_two_y)
  );

  always #5 clk = ~clk;

  // Clamp to the signed coordinate range.
  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Integer square root by the bitwise method.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // One barb coordinate: fixed-point offset, add one half, truncate toward zero.
  function automatic longint barb_coord(longint p, longint n, longint len_fx);
    longint q, total;
    q = (n * (64'sd1 << (2 * FB))) / len_fx;
    total = p * (64'sd1 << FB) + q + (64'sd1 << (FB - 1));
    return clamp_coord(total / (64'sd1 << FB));
  endfunction

  // Shifted end points and the two barb points of one segment.
  function automatic vertices_t arrow_vertices(segment_t s);
    longint x1, y1, x2, y2, dx, dy, len_fx;
    longint unsigned sq;
    vertices_t v;
    x1 = clamp_coord(longint'(s.tx) + longint'(s.ox));
    y1 = clamp_coord(longint'(s.ty) + longint'(s.oy));
    x2 = clamp_coord(longint'(s.px) + longint'(s.ox));
    y2 = clamp_coord(longint'(s.py) + longint'(s.oy));
    dx = x2 - x1;
    dy = y2 - y1;
    sq = dx * dx + dy * dy;
    // Coincident points take a unit vector along x.
    if (sq == 0) begin
      dx = 1;
      len_fx = 64'sd1 << FB;
    end else begin
      len_fx = int_sqrt(sq << (2 * FB));
      if (len_fx == 0) len_fx = 1;
    end
    v[0] = x1[CW-1:0];
    v[1] = y1[CW-1:0];
    v[2] = x2[CW-1:0];
    v[3] = y2[CW-1:0];
    v[4] = CW'(barb_coord(x2, -head_len * dx + head_wid * dy, len_fx));
    v[5] = CW'(barb_coord(y2, -head_len * dy - head_wid * dx, len_fx));
    v[6] = CW'(barb_coord(x2, -head_len * dx - head_wid * dy, len_fx));
    v[7] = CW'(barb_coord(y2, -head_len * dy + head_wid * dx, len_fx));
    return v;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go || hold_cnt > 0) begin
      if (hold_go) begin
        hold_cnt = 300;
        hold_go = 1'b0;
      end
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 6);
    end
  end

  // Check each output transfer against the oldest expected vertex set.
  always @(posedge clk) begin
    vertices_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {barb_two_y, barb_two_x, barb_one_y, barb_one_x,
             out_tip_y, out_tip_x, out_tail_y, out_tail_x};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output transfer: %h", got);
      end else begin
        want = pending_vertices.pop_front();
        vertex_sets_checked++;
        for (int f = 0; f < 8; f++) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch in field %0d of result %0d: expected %0d, got %0d",
                       f, vertex_sets_checked, $signed(want[f]), $signed(got[f]));
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one segment, with an occasional one-cycle gap first, and wait for
  // its transfer. Valid stays high afterwards until the next gap, drain or pause.
  task automatic send_segment(segment_t s);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tail_x <= s.tx; tail_y <= s.ty; tip_x <= s.px; tip_y <= s.py;
    offset_x <= s.ox; offset_y <= s.oy;
    do @(posedge clk); while (in_stall);
    pending_vertices.push_back(arrow_vertices(s));
    segments_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_head(ahvg_pkg::cfg_index_t idx,
                            logic [ahvg_pkg::REG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == ahvg_pkg::CFG_BARB_BACK) head_len = val;
    else head_wid = val;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CW'($urandom);
      1: return $urandom_range(1) ? CW'(16'sh7FFF - $urandom_range(20))
                                  : CW'(16'sh8000 + $urandom_range(20));
      default: return CW'($urandom_range(2000) - 1000);
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.tx = rand_coord(); s.ty = rand_coord();
    s.ox = rand_coord(); s.oy = rand_coord();
    case ($urandom_range(9))
      0: begin s.px = s.tx; s.py = s.ty; end
      1: begin
        s.px = CW'(s.tx + $urandom_range(6) - 3);
        s.py = CW'(s.ty + $urandom_range(6) - 3);
      end
      default: begin s.px = rand_coord(); s.py = rand_coord(); end
    endcase
    return s;
  endfunction

  function automatic segment_t seg(int tx, int ty, int px, int py, int ox, int oy);
    segment_t s;
    s.tx = CW'(tx); s.ty = CW'(ty); s.px = CW'(px); s.py = CW'(py);
    s.ox = CW'(ox); s.oy = CW'(oy);
    return s;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // Alternate stretches of 200 segments with and without idling.
      no_idle = ((segments_sent % 400) >= 200);
      send_segment(rand_segment());
    end
    no_idle = 1'b0;
  endtask

  // Extremes, coincident points, saturation and axis-aligned segments.
  task automatic test_directed();
    send_segment(seg(0, 0, 0, 0, 0, 0));
    send_segment(seg(5, 7, 5, 7, -3, 2));
    send_segment(seg(0, 0, 10, 0, 0, 0));
    send_segment(seg(0, 0, 0, 10, 0, 0));
    send_segment(seg(0, 0, -10, 0, 0, 0));
    send_segment(seg(0, 0, 0, -10, 0, 0));
    send_segment(seg(0, 0, 3, 4, 100, -100));
    send_segment(seg(0, 0, 1, 1, 0, 0));
    send_segment(seg(-32768, -32768, 32767, 32767, 0, 0));
    send_segment(seg(32767, 32767, -32768, -32768, 0, 0));
    send_segment(seg(32767, -32768, 32767, -32768, 32767, -32768));
    send_segment(seg(30000, 30000, 32000, 32000, 10000, 10000));
    send_segment(seg(-30000, -30000, -32000, -32000, -10000, -10000));
    send_segment(seg(100, 100, 32767, -32768, 32767, 32767));
    send_segment(seg(-1, -1, -1, -1, -1, -1));
    send_segment(seg(-32768, 32767, 32767, -32768, -32768, 32767));
    send_segment(seg(32767, 0, 32766, 0, 32767, 0));
    send_segment(seg(0, 16'h5555, 0, -21846, 16'h2AAA, -10923));
    wait_drained();
  endtask

  // Zero head size, largest head size, the mixed extremes and a random head size.
  task automatic test_head_sizes();
    write_head(ahvg_pkg::CFG_BARB_BACK, 8'd0);
    write_head(ahvg_pkg::CFG_BARB_SIDE, 8'd0);
    send_segment(seg(0, 0, 10, 10, 0, 0));
    send_segment(seg(0, 0, 0, 0, 0, 0));
    run_random(120);
    wait_drained();
    write_head(ahvg_pkg::CFG_BARB_BACK, 8'd255);
    write_head(ahvg_pkg::CFG_BARB_SIDE, 8'd255);
    send_segment(seg(-32768, -32768, 32767, 32767, 0, 0));
    send_segment(seg(0, 0, 0, 0, 32767, 32767));
    send_segment(seg(0, 0, 0, 0, -32768, -32768));
    run_random(200);
    wait_drained();
    write_head(ahvg_pkg::CFG_BARB_BACK, 8'd255);
    write_head(ahvg_pkg::CFG_BARB_SIDE, 8'd0);
    run_random(80);
    wait_drained();
    write_head(ahvg_pkg::CFG_BARB_BACK, 8'd0);
    write_head(ahvg_pkg::CFG_BARB_SIDE, 8'd255);
    run_random(80);
    wait_drained();
    write_head(ahvg_pkg::CFG_BARB_BACK, 8'($urandom));
    write_head(ahvg_pkg::CFG_BARB_SIDE, 8'($urandom));
    run_random(150);
    wait_drained();
  endtask

  // The receiver holds off while segments keep coming, so the pipeline fills.
  task automatic test_backpressure();
    hold_go = 1'b1;
    run_random(120);
    wait_drained();
  endtask

  // With the reset head sizes restored, the sender pauses until every result is out, then resumes.
  task automatic test_sender_pause();
    write_head(ahvg_pkg::CFG_BARB_BACK, ahvg_pkg::BARB_BACK_RESET);
    write_head(ahvg_pkg::CFG_BARB_SIDE, ahvg_pkg::BARB_SIDE_RESET);
    run_random(60);
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    run_random(220);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_head_sizes();
    test_backpressure();
    test_sender_pause();
    wait_drained();
    $display("Sent %0d segments and checked %0d vertex sets over several head sizes,",
             segments_sent, vertex_sets_checked);
    $display("with random stalls, a long output hold-off and a sender pause; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ahvg_pkg.sv
hdl/ahvg_sqrt_cell.sv
hdl/ahvg_div_cell.sv
hdl/arrow_head_vertex_generator.sv
verif/tb.sv
